/* hw/rtl/tctb_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the tick counter with timer bank.
// No dependencies; imported by tctb_cell and the top level.
package tctb_pkg;

  localparam int NUM_TIMERS = 8;   // 1 to 8
  localparam int SLOT_W     = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int TICKS_W    = 32;
  localparam int COUNT_W    = 64;
  localparam int MASK_W     = 8;

  localparam logic [2:0] MODE_TICK   = 3'd0;
  localparam logic [2:0] MODE_ALLOC  = 3'd1;
  localparam logic [2:0] MODE_MODIFY = 3'd2;
  localparam logic [2:0] MODE_READ   = 3'd3;
  localparam logic [2:0] MODE_NOTIFY = 3'd4;
  localparam logic [2:0] MODE_COUNT  = 3'd5;

  typedef struct packed {
    logic [2:0]         mode;
    logic [2:0]         timer_index;
    logic [TICKS_W-1:0] timer_ticks;
    logic               repeat_enable;
    logic               notify_enable;
  } cmd_t;

  typedef struct packed {
    logic [2:0]         slot;
    logic               slot_ok;
    logic [MASK_W-1:0]  expired_mask;
    logic [TICKS_W-1:0] remaining;
    logic [COUNT_W-1:0] tick_count;
  } result_t;

  // Data handed from one cell to the next along the bank.
  typedef struct packed {
    logic               alloc_done;   // a lower cell is free (allocate)
    logic [SLOT_W-1:0]  slot;         // slot claimed by allocate
    logic [TICKS_W-1:0] remaining;    // value reported by the selected cell
    logic [MASK_W-1:0]  mask;         // expiries with notify set
  } link_t;

endpackage

/* hw/rtl/tick_counter_with_timer_bank_unit.sv */
`timescale 1ns / 1ps
// Top level: 64-bit tick counter plus a row of timer cells, result register.
// Depends on tctb_pkg and tctb_cell.
//
// Usage: a command word is taken at every rising edge with start high; busy
// stays low, so a new word may follow in every cycle. Each word gives exactly
// one result word, shown on result with done high for exactly one cycle in the
// cycle after the word was taken. The receiver cannot hold results off, so it
// must take the result in that cycle. The allocate search, the addressed
// readback and the expiry mask all ripple cell to cell through the row of
// NUM_TIMERS cells in a single pass, before the edge that takes the word.
// Modes: tick, allocate (lowest slot with zero reload), modify, read remaining,
// set notify, read count; other codes change nothing and report only the tick
// count. Counter, done and slots reset to zero (all slots free); result has no reset.
module tick_counter_with_timer_bank_unit
  import tctb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  output logic    busy,
  input  cmd_t    cmd,
  output logic    done,
  output result_t result
);

  logic [COUNT_W-1:0] tick_counter, tick_counter_next;
  result_t            result_next;
  link_t              link [NUM_TIMERS+1];
  logic               index_valid;

  assign busy = 1'b0;   // never busy: every word is taken as it comes

  assign link[0] = '0;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    tctb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .start    (start),
      .cmd      (cmd),
      .my_index (SLOT_W'(i)),
      .link_in  (link[i]),
      .link_out (link[i+1])
    );
  end

  // wide increment on tick words only
  assign tick_counter_next = (start && (cmd.mode == MODE_TICK)) ?
                             tick_counter + COUNT_W'(1) : tick_counter;

  assign index_valid = (32'(cmd.timer_index) < 32'(NUM_TIMERS));

  always_comb begin
    result_next            = '0;
    result_next.tick_count = tick_counter_next;
    case (cmd.mode)
      MODE_TICK: begin
        result_next.expired_mask = link[NUM_TIMERS].mask;
      end
      MODE_ALLOC: begin
        // no free slot: slot, ok and remaining stay zero
        if (link[NUM_TIMERS].alloc_done) begin
          result_next.slot      = 3'(link[NUM_TIMERS].slot);
          result_next.slot_ok   = 1'b1;
          result_next.remaining = link[NUM_TIMERS].remaining;
        end
      end
      MODE_MODIFY, MODE_READ, MODE_NOTIFY: begin
        result_next.slot      = cmd.timer_index;
        result_next.slot_ok   = index_valid;
        result_next.remaining = link[NUM_TIMERS].remaining;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_counter <= '0;
      done         <= 1'b0;
    end else begin
      tick_counter <= tick_counter_next;
      done         <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      result <= result_next;
    end
  end

  // Counter moves by one on a tick word and holds otherwise.
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    (start && (cmd.mode == MODE_TICK)) |=> (tick_counter == $past(tick_counter) + 64'd1))
    else $error("tick counter did not advance by one");

  a_tick_hold: assert property (@(posedge clk) disable iff (rst)
    !(start && (cmd.mode == MODE_TICK)) |=> $stable(tick_counter))
    else $error("tick counter moved without a tick");

  // Expiry bits appear only in answer to a tick.
  a_mask_tick: assert property (@(posedge clk) disable iff (rst)
    (start && (cmd.mode != MODE_TICK)) |=> (result.expired_mask == '0))
    else $error("expiry mask on a non-tick word");

  // A read-count word never reports a slot.
  a_count_noslot: assert property (@(posedge clk) disable iff (rst)
    (start && (cmd.mode == MODE_COUNT)) |=> (!result.slot_ok && result.remaining == '0))
    else $error("read count reported a slot");

endmodule

/* hw/rtl/tctb_cell.sv */
`timescale 1ns / 1ps
// One timer slot of the bank: reload, remaining count and flags.
// Depends on tctb_pkg.
module tctb_cell
  import tctb_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  cmd_t              cmd,
  input  logic [SLOT_W-1:0] my_index,
  input  link_t             link_in,
  output link_t             link_out
);

  logic [TICKS_W-1:0] reload, reload_next;
  logic [TICKS_W-1:0] count, count_next;
  logic               rep, rep_next;
  logic               note, note_next;

  logic               is_free;
  logic               addressed;
  logic               alloc_me;
  logic               load;
  logic               selected;
  logic               expire;
  logic [TICKS_W-1:0] count_dec;

  assign is_free   = (reload == '0);
  assign addressed = (32'(cmd.timer_index) == 32'(my_index));
  assign alloc_me  = (cmd.mode == MODE_ALLOC) && !link_in.alloc_done && is_free;
  assign load      = alloc_me || ((cmd.mode == MODE_MODIFY) && addressed);
  assign selected  = alloc_me || (addressed && ((cmd.mode == MODE_MODIFY) ||
                     (cmd.mode == MODE_READ) || (cmd.mode == MODE_NOTIFY)));
  assign count_dec = count - TICKS_W'(1);
  // counting down from one is the expiry
  assign expire    = (cmd.mode == MODE_TICK) && (count == TICKS_W'(1));

  always_comb begin
    reload_next = reload;
    count_next  = count;
    rep_next    = rep;
    note_next   = note;
    if (start) begin
      if (load) begin
        reload_next = cmd.timer_ticks;
        count_next  = cmd.timer_ticks;
        rep_next    = cmd.repeat_enable;
        note_next   = cmd.notify_enable;
      end else if ((cmd.mode == MODE_NOTIFY) && addressed) begin
        note_next = cmd.notify_enable;
      end else if ((cmd.mode == MODE_TICK) && (count != '0)) begin
        if (expire) begin
          count_next = rep ? reload : '0;
        end else begin
          count_next = count_dec;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reload <= '0;
      count  <= '0;
      rep    <= 1'b0;
      note   <= 1'b0;
    end else begin
      reload <= reload_next;
      count  <= count_next;
      rep    <= rep_next;
      note   <= note_next;
    end
  end

  always_comb begin
    link_out.alloc_done = link_in.alloc_done || ((cmd.mode == MODE_ALLOC) && is_free);
    link_out.slot       = alloc_me ? my_index : link_in.slot;
    link_out.remaining  = link_in.remaining |
                          (selected ? (load ? cmd.timer_ticks : count) : '0);
    // slots at eight and above shift out of the mask
    link_out.mask       = link_in.mask |
                          ((expire && note) ? (MASK_W'(1) << my_index) : '0);
  end

endmodule

/* bench/timer_bank_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the tick counter with timer bank: keeps its own copy of the
// counter and the timer slots, predicts every result word and compares it.
// Depends on tctb_pkg.
module timer_bank_checker
  import tctb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    busy,
  input  cmd_t    cmd,
  input  logic    done,
  input  result_t result,
  output int      mismatch_count,
  output int      pending_results
);

  logic [COUNT_W-1:0] ticks_seen;
  logic [TICKS_W-1:0] period_q    [NUM_TIMERS];
  logic [TICKS_W-1:0] countdown_q [NUM_TIMERS];
  logic               repeat_q    [NUM_TIMERS];
  logic               notify_q    [NUM_TIMERS];

  result_t expected_results[$];

  function automatic void load_timer(int n, logic [TICKS_W-1:0] period, logic rep,
                                     logic note);
    period_q[n]    = period;
    countdown_q[n] = period;
    repeat_q[n]    = rep;
    notify_q[n]    = note;
  endfunction

  // Applies one command word to the shadow state, returns the result word.
  function automatic result_t timer_bank_result(cmd_t c);
    result_t r;
    logic    in_range;
    logic    claimed;
    int      idx;
    r        = '0;
    idx      = int'(c.timer_index);
    in_range = (idx < NUM_TIMERS);
    claimed  = 1'b0;
    case (c.mode)
      MODE_TICK: begin
        ticks_seen = ticks_seen + COUNT_W'(1);
        for (int n = 0; n < NUM_TIMERS; n++) begin
          if (countdown_q[n] != '0) begin
            countdown_q[n] = countdown_q[n] - TICKS_W'(1);
            if (countdown_q[n] == '0) begin
              if (repeat_q[n]) countdown_q[n] = period_q[n];
              // only the low slots have a mask bit
              if (notify_q[n] && n < MASK_W) r.expired_mask[n] = 1'b1;
            end
          end
        end
      end
      MODE_ALLOC: begin
        // lowest free slot wins; a zero period claims it but leaves it free
        for (int n = 0; n < NUM_TIMERS; n++) begin
          if (!claimed && period_q[n] == '0) begin
            load_timer(n, c.timer_ticks, c.repeat_enable, c.notify_enable);
            r.slot      = 3'(n);
            r.slot_ok   = 1'b1;
            r.remaining = countdown_q[n];
            claimed     = 1'b1;
          end
        end
      end
      MODE_MODIFY, MODE_READ, MODE_NOTIFY: begin
        r.slot = c.timer_index;
        if (in_range) begin
          if (c.mode == MODE_MODIFY)
            load_timer(idx, c.timer_ticks, c.repeat_enable, c.notify_enable);
          else if (c.mode == MODE_NOTIFY)
            notify_q[idx] = c.notify_enable;
          r.slot_ok   = 1'b1;
          r.remaining = countdown_q[idx];
        end
      end
      default: ;  // read count and undefined codes only report the counter
    endcase
    r.tick_count = ticks_seen;
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    logic    bad;
    if (rst) begin
      ticks_seen = '0;
      for (int n = 0; n < NUM_TIMERS; n++) load_timer(n, '0, 1'b0, 1'b0);
      expected_results.delete();
      mismatch_count = 0;
    end else begin
      // the result of a word shows in the cycle after it is taken, so check first
      if (done) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result word, expected none, got %h", $time, result);
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          bad  = 1'b0;
          if (result.slot !== want.slot) begin
            $display("%0t: slot expected %0d got %0d", $time, want.slot, result.slot);
            bad = 1'b1;
          end
          if (result.slot_ok !== want.slot_ok) begin
            $display("%0t: slot_ok expected %0b got %0b", $time, want.slot_ok,
                     result.slot_ok);
            bad = 1'b1;
          end
          if (result.expired_mask !== want.expired_mask) begin
            $display("%0t: expired_mask expected %h got %h", $time, want.expired_mask,
                     result.expired_mask);
            bad = 1'b1;
          end
          if (result.remaining !== want.remaining) begin
            $display("%0t: remaining expected %h got %h", $time, want.remaining,
                     result.remaining);
            bad = 1'b1;
          end
          if (result.tick_count !== want.tick_count) begin
            $display("%0t: tick_count expected %h got %h", $time, want.tick_count,
                     result.tick_count);
            bad = 1'b1;
          end
          if (bad) mismatch_count++;
        end
      end
      if (start && !busy) expected_results.push_back(timer_bank_result(cmd));
    end
    pending_results = expected_results.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// Stimulus and verdict for the tick counter with timer bank unit.
// Depends on tctb_pkg, tick_counter_with_timer_bank_unit and timer_bank_checker.
module tb_top;
  import tctb_pkg::*;

  // codes the block leaves undefined; they must change nothing
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  localparam int WORDS_PER_PHASE = 200;
  localparam int CYCLE_LIMIT     = 100000;
  localparam int SETTLE_CYCLES   = 4;       // margin for the last result word

  logic    clk;
  logic    rst;
  logic    start;
  logic    busy;
  cmd_t    cmd;
  logic    done;
  result_t result;

  int mismatch_count;
  int pending_results;
  int cycle_count;
  int idle_pct;

  tick_counter_with_timer_bank_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .done   (done),
    .result (result)
  );

  timer_bank_checker u_check (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .cmd             (cmd),
    .done            (done),
    .result          (result),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends here
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Drives one word from a falling edge, holds it until taken. Random idle
  // cycles go in front of the word so gaps land between any two words.
  task automatic issue(input logic [2:0] mode, input logic [2:0] index,
                       input logic [TICKS_W-1:0] period, input logic rep,
                       input logic note);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start             <= 1'b1;
    cmd.mode          <= mode;
    cmd.timer_index   <= index;
    cmd.timer_ticks   <= period;
    cmd.repeat_enable <= rep;
    cmd.notify_enable <= note;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Sender holds off until every predicted result word is back.
  task automatic drain();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results != 0) @(negedge clk);
  endtask

  // Mostly short periods so timers expire and reload often; zero frees slots,
  // and some full-range values exercise every bit of the field.
  function automatic logic [TICKS_W-1:0] pick_period();
    int roll;
    roll = $urandom_range(99);
    if (roll < 55) return TICKS_W'($urandom_range(1, 6));
    if (roll < 70) return TICKS_W'($urandom_range(7, 40));
    if (roll < 85) return '0;
    if (roll < 95) return TICKS_W'($urandom);
    return '1;
  endfunction

  function automatic logic [2:0] pick_mode();
    int roll;
    roll = $urandom_range(99);
    if (roll < 35) return MODE_TICK;
    if (roll < 47) return MODE_ALLOC;
    if (roll < 62) return MODE_MODIFY;
    if (roll < 77) return MODE_READ;
    if (roll < 87) return MODE_NOTIFY;
    if (roll < 94) return MODE_COUNT;
    return $urandom_range(1) ? MODE_SPARE_HI : MODE_SPARE_LO;
  endfunction

  task automatic random_phase(input int pct);
    idle_pct = pct;
    for (int i = 0; i < WORDS_PER_PHASE; i++) begin
      issue(pick_mode(), 3'($urandom_range(7)), pick_period(), 1'($urandom_range(1)),
            1'($urandom_range(1)));
      // one extra full stop in the middle of the phase with the most idle cycles
      if (pct == 55 && i == WORDS_PER_PHASE / 2) drain();
    end
    drain();
  endtask

  initial begin
    rst      = 1'b1;
    start    = 1'b0;
    cmd      = '0;
    idle_pct = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty bank, counter read
    issue(MODE_COUNT, 3'd0, '0, 1'b0, 1'b0);
    issue(MODE_TICK, 3'd0, '0, 1'b0, 1'b0);
    // zero-period allocate reports slot 0 but leaves it free
    issue(MODE_ALLOC, 3'd5, '0, 1'b1, 1'b1);
    // fill all eight slots: periodic, one-shot, quiet, huge period
    issue(MODE_ALLOC, 3'd0, 32'd1, 1'b1, 1'b1);
    issue(MODE_ALLOC, 3'd0, 32'd2, 1'b0, 1'b1);
    issue(MODE_ALLOC, 3'd0, 32'd3, 1'b1, 1'b0);
    issue(MODE_ALLOC, 3'd7, '1, 1'b1, 1'b1);
    issue(MODE_ALLOC, 3'd0, 32'd4, 1'b0, 1'b0);
    issue(MODE_ALLOC, 3'd0, 32'd5, 1'b1, 1'b1);
    issue(MODE_ALLOC, 3'd0, 32'd6, 1'b0, 1'b1);
    issue(MODE_ALLOC, 3'd0, 32'd2, 1'b1, 1'b1);
    // bank full: allocate must fail and change nothing
    issue(MODE_ALLOC, 3'd0, 32'd9, 1'b1, 1'b1);
    issue(MODE_TICK, 3'd0, '0, 1'b0, 1'b0);
    issue(MODE_TICK, 3'd0, '0, 1'b0, 1'b0);
    issue(MODE_TICK, 3'd0, '0, 1'b0, 1'b0);
    issue(MODE_READ, 3'd1, '0, 1'b0, 1'b0);
    issue(MODE_READ, 3'd3, '0, 1'b0, 1'b0);
    issue(MODE_NOTIFY, 3'd2, '0, 1'b0, 1'b1);
    issue(MODE_NOTIFY, 3'd0, '1, 1'b1, 1'b0);
    // modify with zero frees slot 4; then a fresh allocate should take it
    issue(MODE_MODIFY, 3'd4, '0, 1'b1, 1'b1);
    issue(MODE_ALLOC, 3'd0, 32'd1, 1'b1, 1'b1);
    issue(MODE_SPARE_LO, 3'd7, '1, 1'b1, 1'b1);
    issue(MODE_SPARE_HI, 3'd7, '1, 1'b1, 1'b1);
    issue(MODE_TICK, 3'd0, '0, 1'b0, 1'b0);
    issue(MODE_COUNT, 3'd7, '1, 1'b1, 1'b1);
    drain();

    random_phase(19);
    random_phase(55);
    random_phase(0);

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
